### rtl/core/tama_pkg.sv
// ----------------------------------------------------------------------------
// tama_pkg: shared definitions for the three-axis moving average
// Default sizes and the control bundle that steps each axis lane.
// ----------------------------------------------------------------------------
package tama_pkg;

	// Default window length in samples and default sample width in bits.
	localparam int WindowDepthDef = 16;
	localparam int SampleBitsDef  = 24;

	// Per-cycle commands from the sequencer to every axis lane.
	typedef struct packed {
		logic clear;     // drop the running sum (restart item)
		logic load;      // load sample and retired slot into the shift registers
		logic add_step;  // one bit of the serial sum update
		logic pick;      // select the sum magnitude as the dividend
		logic div_step;  // one bit of the restoring division
	} lane_ctrl_t;

endpackage

### rtl/core/tama_ram.sv
// ----------------------------------------------------------------------------
// tama_ram: generic single-write, single-read memory
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module tama_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/tama_lane.sv
// ----------------------------------------------------------------------------
// tama_lane: one axis of the moving average
// Bit-serial update of the running sum, then a bit-serial restoring divide
// of the sum magnitude by the sample count.
// ----------------------------------------------------------------------------
module tama_lane #(
	parameter int SAMPLE_BITS = tama_pkg::SampleBitsDef,
	parameter int SUM_BITS    = tama_pkg::SampleBitsDef + 8,
	parameter int COUNT_BITS  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tama_pkg::lane_ctrl_t          ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [SAMPLE_BITS-1:0]        old_data,
	input  logic                          old_valid,
	input  logic [COUNT_BITS-1:0]         divisor,
	output logic signed [SAMPLE_BITS-1:0] mean
);

	localparam int EXT_BITS = SUM_BITS - SAMPLE_BITS;

	logic [SUM_BITS-1:0]    total_q;
	logic [SUM_BITS-1:0]    add_sr_q;    // new sample, later the dividend
	logic [SUM_BITS-1:0]    sub_sr_q;    // retired sample, later the negated sum
	logic                   c_add_q;
	logic                   c_sub_q;
	logic                   seen_one_q;
	logic                   neg_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [SAMPLE_BITS-1:0] quot_q;

	logic bit_a;
	logic bit_sum;
	logic bit_old_n;
	logic bit_neg;
	logic c_add_d;
	logic c_sub_d;

	logic [COUNT_BITS:0] rem_sh;
	logic [COUNT_BITS:0] div_ext;
	logic [COUNT_BITS:0] rem_diff;
	logic                rem_ge;

	// Sum bit: total + sample - old, the subtraction as adding the inverse plus one.
	always_comb begin
		bit_a     = total_q[0] ^ add_sr_q[0] ^ c_add_q;
		c_add_d   = (total_q[0] & add_sr_q[0]) | (c_add_q & (total_q[0] ^ add_sr_q[0]));
		bit_old_n = ~sub_sr_q[0];
		bit_sum   = bit_a ^ bit_old_n ^ c_sub_q;
		c_sub_d   = (bit_a & bit_old_n) | (c_sub_q & (bit_a ^ bit_old_n));
		// Negation runs alongside: copy up to the first one, invert above it.
		bit_neg   = bit_sum ^ seen_one_q;
	end

	always_comb begin
		rem_sh   = {rem_q, add_sr_q[SUM_BITS-1]};
		div_ext  = {1'b0, divisor};
		rem_ge   = (rem_sh >= div_ext);
		rem_diff = rem_sh - div_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctrl.clear) begin
			total_q <= '0;
		end else if (ctrl.add_step) begin
			total_q <= {bit_sum, total_q[SUM_BITS-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			add_sr_q   <= {{EXT_BITS{sample[SAMPLE_BITS-1]}}, sample};
			sub_sr_q   <= old_valid ? {{EXT_BITS{old_data[SAMPLE_BITS-1]}}, old_data} : '0;
			c_add_q    <= 1'b0;
			c_sub_q    <= 1'b1;
			seen_one_q <= 1'b0;
		end else if (ctrl.add_step) begin
			add_sr_q   <= {1'b0, add_sr_q[SUM_BITS-1:1]};
			sub_sr_q   <= {bit_neg, sub_sr_q[SUM_BITS-1:1]};
			c_add_q    <= c_add_d;
			c_sub_q    <= c_sub_d;
			seen_one_q <= seen_one_q | bit_sum;
		end else if (ctrl.pick) begin
			neg_q    <= total_q[SUM_BITS-1];
			add_sr_q <= total_q[SUM_BITS-1] ? sub_sr_q : total_q;
			rem_q    <= '0;
			quot_q   <= '0;
		end else if (ctrl.div_step) begin
			add_sr_q <= {add_sr_q[SUM_BITS-2:0], 1'b0};
			rem_q    <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
			quot_q   <= {quot_q[SAMPLE_BITS-2:0], rem_ge};
		end
	end

	// The quotient of the magnitude always fits the sample width.
	assign mean = neg_q ? (~quot_q + SAMPLE_BITS'(1)) : quot_q;

endmodule

### rtl/core/three_axis_moving_average.sv
// ----------------------------------------------------------------------------
// three_axis_moving_average: boxcar average over up to the last WINDOW_DEPTH samples
// Items are handled one at a time: the next item is accepted only once the
// last result is in the output register. The bit-serial sum update and the
// bit-serial divider each work one bit a cycle.
// Reset clears the count, write slot and sums at once; no clearing pass needed.
// ----------------------------------------------------------------------------
module three_axis_moving_average #(
	parameter int WINDOW_DEPTH = tama_pkg::WindowDepthDef,
	parameter int SAMPLE_BITS  = tama_pkg::SampleBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_x,
	input  logic signed [SAMPLE_BITS-1:0] sample_y,
	input  logic signed [SAMPLE_BITS-1:0] sample_z,
	input  logic                          restart,
	output logic                          mean_valid,
	input  logic                          mean_stall,
	output logic signed [SAMPLE_BITS-1:0] mean_x,
	output logic signed [SAMPLE_BITS-1:0] mean_y,
	output logic signed [SAMPLE_BITS-1:0] mean_z,
	output logic                          warmed_up
);

	// Eight bits of growth hold the exact sum of up to 256 samples.
	localparam int SUM_BITS   = SAMPLE_BITS + 8;
	localparam int SLOT_BITS  = $clog2(WINDOW_DEPTH);
	localparam int COUNT_BITS = $clog2(WINDOW_DEPTH + 1);
	localparam int BIT_BITS   = $clog2(SUM_BITS);
	localparam int RAM_WIDTH  = 3 * SAMPLE_BITS;

	// Sequencer: fetch the retired slot, update the sums bit by bit, take the
	// magnitude, divide bit by bit, then hand the result to the output register.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_ADD  = 6'b000100,
		ST_PICK = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_eff;
	logic [SLOT_BITS-1:0]  slot_q;
	logic                  full_q;
	logic [BIT_BITS-1:0]   bit_cnt_q;
	logic                  bit_last;

	logic                   accept;
	logic                   out_free;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] sample_x_q;
	logic [SAMPLE_BITS-1:0] sample_y_q;
	logic [SAMPLE_BITS-1:0] sample_z_q;

	logic [RAM_WIDTH-1:0]   ram_rd_data;
	tama_pkg::lane_ctrl_t   lane_ctrl;

	logic signed [SAMPLE_BITS-1:0] lane_mean_x;
	logic signed [SAMPLE_BITS-1:0] lane_mean_y;
	logic signed [SAMPLE_BITS-1:0] lane_mean_z;

	logic                   mean_valid_q;
	logic [SAMPLE_BITS-1:0] mean_x_q;
	logic [SAMPLE_BITS-1:0] mean_y_q;
	logic [SAMPLE_BITS-1:0] mean_z_q;
	logic                   warmed_up_q;

	// An item is taken only while the sequencer is idle. A finished result sits
	// in the output register, so the next item can enter while it waits.
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !mean_valid_q || !mean_stall;
	assign out_load     = (state_q == ST_FIN) && out_free;
	assign bit_last     = (bit_cnt_q == BIT_BITS'(SUM_BITS - 1));

	// A restart item starts a fresh window before its own sample is counted.
	assign count_eff = restart ? '0 : count_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_ADD;
			ST_ADD: begin
				if (bit_last) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: state_d = ST_DIV;
			ST_DIV: begin
				if (bit_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Slots are written in order from zero after reset or restart, so until the
	// window is full the slot being overwritten holds no sample of the window. The
	// full flag alone decides whether its stored value takes part in the sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			slot_q       <= '0;
			full_q       <= 1'b0;
			bit_cnt_q    <= '0;
			mean_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				full_q  <= (count_eff == COUNT_BITS'(WINDOW_DEPTH));
				count_q <= (count_eff == COUNT_BITS'(WINDOW_DEPTH)) ?
					count_eff : count_eff + COUNT_BITS'(1);
				if (restart) begin
					slot_q <= '0;
				end
			end
			if (out_load) begin
				slot_q <= (slot_q == SLOT_BITS'(WINDOW_DEPTH - 1)) ?
					'0 : slot_q + SLOT_BITS'(1);
			end
			if ((state_q == ST_ADD) || (state_q == ST_DIV)) begin
				bit_cnt_q <= bit_last ? '0 : bit_cnt_q + BIT_BITS'(1);
			end else begin
				bit_cnt_q <= '0;
			end
			if (out_load) begin
				mean_valid_q <= 1'b1;
			end else if (!mean_stall) begin
				mean_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_x_q <= sample_x;
			sample_y_q <= sample_y;
			sample_z_q <= sample_z;
		end
		if (out_load) begin
			mean_x_q    <= lane_mean_x;
			mean_y_q    <= lane_mean_y;
			mean_z_q    <= lane_mean_z;
			warmed_up_q <= (count_q == COUNT_BITS'(WINDOW_DEPTH));
		end
	end

	// The retired slot is read on acceptance and overwritten with the new
	// sample in the following cycle, once its old value is in the read register.
	tama_ram #(
		.WIDTH(RAM_WIDTH),
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (state_q == ST_READ),
		.wr_addr(slot_q),
		.wr_data({sample_z_q, sample_y_q, sample_x_q}),
		.rd_en  (accept),
		.rd_addr(restart ? '0 : slot_q),
		.rd_data(ram_rd_data)
	);

	always_comb begin
		lane_ctrl          = '0;
		lane_ctrl.clear    = accept && restart;
		lane_ctrl.load     = (state_q == ST_READ);
		lane_ctrl.add_step = (state_q == ST_ADD);
		lane_ctrl.pick     = (state_q == ST_PICK);
		lane_ctrl.div_step = (state_q == ST_DIV);
	end

	// The three axes run side by side in identical lanes.
	tama_lane #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_BITS   (SUM_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lane_ctrl),
		.sample   (sample_x_q),
		.old_data (ram_rd_data[SAMPLE_BITS-1:0]),
		.old_valid(full_q),
		.divisor  (count_q),
		.mean     (lane_mean_x)
	);

	tama_lane #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_BITS   (SUM_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lane_ctrl),
		.sample   (sample_y_q),
		.old_data (ram_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.old_valid(full_q),
		.divisor  (count_q),
		.mean     (lane_mean_y)
	);

	tama_lane #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_BITS   (SUM_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_lane_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lane_ctrl),
		.sample   (sample_z_q),
		.old_data (ram_rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
		.old_valid(full_q),
		.divisor  (count_q),
		.mean     (lane_mean_z)
	);

	assign mean_valid = mean_valid_q;
	assign mean_x     = mean_x_q;
	assign mean_y     = mean_y_q;
	assign mean_z     = mean_z_q;
	assign warmed_up  = warmed_up_q;

	// The count never passes the window length.
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(WINDOW_DEPTH))
		else $error("sample count beyond window length");

	// While filling, the write slot tracks the count; the masking relies on it.
	a_slot_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && (count_q < COUNT_BITS'(WINDOW_DEPTH))
		|-> ({1'b0, slot_q} == (SLOT_BITS + 1)'(count_q)))
		else $error("write slot out of step with sample count");

	// The divider never runs with a zero divisor.
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (count_q != '0))
		else $error("division by a zero count");

	// A result appears only when the sequencer finishes an item.
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mean_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result presented without a finished item");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for three_axis_moving_average
// A golden boxcar model predicts the three means and the warm-up flag for
// every item accepted on the sample channel. A checker compares each item
// on the mean channel with the oldest prediction. The stimulus is a directed
// warm-up, wrap and restart sequence followed by random streams with sender
// gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

	// Block sizes come from the package so that the bench follows the RTL defaults.
	localparam int WINDOW   = tama_pkg::WindowDepthDef;
	localparam int SB       = tama_pkg::SampleBitsDef;
	localparam int SUM_BITS = SB + 8;

	// Cycles from the acceptance of one item to its result while the output is not stalled.
	localparam int LATENCY  = 2 * (SB + 8) + 3;

	// The watchdog fires after this many cycles without any handshake. The
	// longest legal quiet stretch is the output hold-off plus one item of
	// latency plus the longest sender gap, so this leaves ample margin.
	localparam int HOLD_CYCLES = 2000;
	localparam int IDLE_LIMIT  = 10000;
	localparam int MAX_REPORTS = 10;

	typedef logic signed [SB-1:0]       sample_t;
	typedef logic signed [SUM_BITS-1:0] total_t;

	// One predicted output item.
	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
		logic    warm;
	} mean_rec_t;

	localparam sample_t SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam sample_t SMIN = {1'b1, {(SB-1){1'b0}}};

	// ------------------------------------------------------------------------
	// Clock, reset and the ports of the block.
	// ------------------------------------------------------------------------
	logic    clk = 1'b0;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample_x;
	sample_t sample_y;
	sample_t sample_z;
	logic    restart;
	logic    mean_valid;
	logic    mean_stall = 1'b0;
	sample_t mean_x;
	sample_t mean_y;
	sample_t mean_z;
	logic    warmed_up;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	three_axis_moving_average dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.sample_z     (sample_z),
		.restart      (restart),
		.mean_valid   (mean_valid),
		.mean_stall   (mean_stall),
		.mean_x       (mean_x),
		.mean_y       (mean_y),
		.mean_z       (mean_z),
		.warmed_up    (warmed_up)
	);

	// ------------------------------------------------------------------------
	// Golden window model. Index 0, 1 and 2 of the axis dimension stand for
	// x, y and z. The rings start at zero, so subtracting a slot that was
	// never written changes nothing.
	// ------------------------------------------------------------------------
	sample_t     ring [3][WINDOW];
	total_t      run_sum [3];
	int unsigned head_slot;
	int unsigned fill_count;

	mean_rec_t   pending_means [$];
	int          mismatch_count = 0;

	function automatic void clear_window();
		for (int a = 0; a < 3; a++) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring[a][i] = '0;
			end
			run_sum[a] = '0;
		end
		head_slot  = 0;
		fill_count = 0;
	endfunction

	// Absorbs one sample into the window and returns the means it produces.
	// Division of the signed sum by the count truncates toward zero, which
	// is what SystemVerilog integer division does.
	function automatic mean_rec_t advance_window(input sample_t sx, input sample_t sy,
			input sample_t sz, input logic rst);
		sample_t   smp [3];
		sample_t   avg [3];
		longint    quot;
		mean_rec_t rec;
		if (rst) begin
			clear_window();
		end
		smp[0] = sx;
		smp[1] = sy;
		smp[2] = sz;
		if (fill_count < WINDOW) begin
			fill_count++;
		end
		for (int a = 0; a < 3; a++) begin
			run_sum[a] = run_sum[a] - ring[a][head_slot] + smp[a];
			ring[a][head_slot] = smp[a];
			quot = longint'(run_sum[a]) / longint'(fill_count);
			avg[a] = quot[SB-1:0];
		end
		head_slot = (head_slot + 1) % WINDOW;
		rec.x    = avg[0];
		rec.y    = avg[1];
		rec.z    = avg[2];
		rec.warm = (fill_count == WINDOW);
		return rec;
	endfunction

	// ------------------------------------------------------------------------
	// Sender. Items go out in bursts of random length separated by random
	// gaps while gaps_on is set; with gaps_on clear, valid stays high from one
	// item to the next. The task is entered just after a rising edge and
	// returns at the edge that accepted the item, so the next call drives its
	// payload in the same time step without lowering valid in between.
	// ------------------------------------------------------------------------
	bit gaps_on   = 1'b0;
	int gap_max   = 1;
	int burst_left = 0;

	task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz,
			input logic rst);
		if (gaps_on && burst_left == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		sample_valid <= 1'b1;
		sample_x     <= sx;
		sample_y     <= sy;
		sample_z     <= sz;
		restart      <= rst;
		@(posedge clk);
		while (sample_stall) begin
			@(posedge clk);
		end
		// The item was taken at this edge, so its means become due now.
		pending_means.push_back(advance_window(sx, sy, sz, rst));
	endtask

	// ------------------------------------------------------------------------
	// Receiver. The stall pattern alternates runs of stall and of flow, with
	// stall_pct setting how often a run is a stall run. A hold-off request
	// keeps stall high for a counted stretch regardless of the pattern.
	// ------------------------------------------------------------------------
	int stall_pct    = 0;
	int hold_request = 0;
	int hold_left    = 0;
	int stall_run    = 0;
	bit stall_state  = 1'b0;

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			mean_stall <= 1'b1;
		end else if (stall_pct == 0) begin
			mean_stall <= 1'b0;
		end else begin
			if (stall_run == 0) begin
				stall_state = ($urandom_range(0, 99) < stall_pct);
				stall_run   = stall_state ? $urandom_range(1, 12) : $urandom_range(1, 8);
			end
			stall_run--;
			mean_stall <= stall_state;
		end
	end

	// ------------------------------------------------------------------------
	// Checker. Outputs are sampled at the rising edge, before any update made
	// at that edge, and every accepted item is matched against the oldest
	// prediction field by field.
	// ------------------------------------------------------------------------
	mean_rec_t want;

	always @(posedge clk) begin
		if (arst_n && mean_valid && !mean_stall) begin
			if (pending_means.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("unexpected mean item: x=%0d y=%0d z=%0d warm=%0b",
						mean_x, mean_y, mean_z, warmed_up);
				end
			end else begin
				want = pending_means.pop_front();
				if (mean_x !== want.x || mean_y !== want.y || mean_z !== want.z ||
						warmed_up !== want.warm) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("mean mismatch: expected x=%0d y=%0d z=%0d warm=%0b",
							want.x, want.y, want.z, want.warm);
						$display("                    got x=%0d y=%0d z=%0d warm=%0b",
							mean_x, mean_y, mean_z, warmed_up);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog. Any handshake on either channel restarts the count.
	// ------------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (mean_valid && !mean_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Random sample values: mostly full-range words, so that every bit takes
	// both values, plus small values that make truncation visible, the
	// extremes, and values close to full scale.
	// ------------------------------------------------------------------------
	function automatic sample_t pick_value();
		int style;
		style = $urandom_range(0, 9);
		if (style <= 5) begin
			return sample_t'($urandom);
		end else if (style <= 7) begin
			return sample_t'(int'($urandom_range(0, 16)) - 8);
		end else if (style == 8) begin
			case ($urandom_range(0, 3))
				0: return SMAX;
				1: return SMIN;
				2: return '0;
				default: return '1;
			endcase
		end else if ($urandom_range(0, 1) == 1) begin
			return SMAX - sample_t'($urandom_range(0, 15));
		end else begin
			return SMIN + sample_t'($urandom_range(0, 15));
		end
	endfunction

	// A restart comes on average once every restart_odds items, so most of
	// the stream runs through full windows and wraps around the ring.
	task automatic run_random(input int count, input int restart_odds);
		for (int i = 0; i < count; i++) begin
			send_sample(pick_value(), pick_value(), pick_value(),
				$urandom_range(1, restart_odds) == 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Test tasks.
	// ------------------------------------------------------------------------

	// Sixteen items at full scale fill the window, so the x and y sums reach
	// their extremes and the flag rises on the last one. The first item also
	// carries a restart on an empty window, and before the window fills, the
	// slots not yet written take no part in the sums. Two more items then wrap
	// the ring and subtract full-scale values from the sums.
	task automatic test_warmup_extremes();
		for (int i = 0; i < WINDOW; i++) begin
			send_sample(SMAX, SMIN, (i % 2 == 0) ? SMIN : SMAX, i == 0);
		end
		send_sample(SMIN, SMAX, '0, 1'b0);
		send_sample(SMIN, SMAX, '1, 1'b0);
	endtask

	// A restart on a warm window makes its own sample the first of a fresh
	// window. The next mean of -3 and 0 must be -1, not -2, since the
	// division truncates toward zero. Back-to-back restarts follow.
	task automatic test_restart();
		send_sample(sample_t'(-3), sample_t'(3), SMIN, 1'b1);
		send_sample('0, '0, SMAX, 1'b0);
		send_sample(sample_t'(5), sample_t'(-5), sample_t'(1), 1'b1);
		send_sample(sample_t'(-8), sample_t'(7), '0, 1'b1);
		send_sample(sample_t'(1), sample_t'(-1), '0, 1'b0);
	endtask

	// A stream with no idling on either side.
	task automatic test_free_running();
		gaps_on   = 1'b0;
		stall_pct = 0;
		run_random(120, 40);
	endtask

	// Sender gaps of up to more than one item of work, so that they fall on every
	// phase of the serial sum update and of the divider, plus light stalls.
	task automatic test_idle_gaps();
		gaps_on   = 1'b1;
		gap_max   = LATENCY + 10;
		stall_pct = 30;
		run_random(200, 40);
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering items back to back, so the block fills and stalls its input.
	task automatic test_output_hold();
		gaps_on      = 1'b0;
		stall_pct    = 0;
		hold_request = HOLD_CYCLES;
		run_random(60, 40);
	endtask

	// Frequent restarts keep the window mostly partial, which exercises the
	// divider with every count from one up to the full window.
	task automatic test_short_windows();
		gaps_on   = 1'b1;
		gap_max   = 8;
		stall_pct = 20;
		run_random(120, 6);
	endtask

	// Heavy back pressure with short sender gaps.
	task automatic test_heavy_stall();
		gaps_on   = 1'b1;
		gap_max   = 4;
		stall_pct = 80;
		run_random(200, 40);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		// Every input is known from time zero, with reset asserted.
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_x     = '0;
		sample_y     = '0;
		sample_z     = '0;
		restart      = 1'b0;
		clear_window();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_warmup_extremes();
		test_restart();
		test_free_running();
		test_idle_gaps();
		test_output_hold();
		test_short_windows();
		test_heavy_stall();

		// Stop offering items, wait for every predicted mean to come back,
		// then give the block time to show any stray output item.
		sample_valid <= 1'b0;
		while (pending_means.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * LATENCY) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
